// ===== rtl/nss_pkg.sv =====
// Shared types and constants for the NTSC scan line sequencer.
`timescale 1ns / 1ps

package nss_pkg;

    // Input commands
    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_LOAD_FRAME = 2'd1;
    localparam logic [1:0] CMD_LOAD_SOUND = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST_VIDEO = 2'd0;
    localparam logic [1:0] CFG_LAST_VIDEO  = 2'd1;
    localparam logic [1:0] CFG_LINE_REPEAT = 2'd2;

    // Sync pulse kinds
    localparam logic [1:0] PULSE_HSYNC = 2'd0;
    localparam logic [1:0] PULSE_SERR  = 2'd1;
    localparam logic [1:0] PULSE_BROAD = 2'd2;

    // Scan lines that mark vertical sync and field events
    localparam logic [8:0] LINE_HALF_START = 9'd1;
    localparam logic [8:0] LINE_BROAD      = 9'd7;
    localparam logic [8:0] LINE_SERR_AGAIN = 9'd13;
    localparam logic [8:0] LINE_VS_END_ODD = 9'd18;
    localparam logic [8:0] LINE_VS_END_EVN = 9'd19;
    localparam logic [8:0] LINE_FLD_END_ODD = 9'd271;
    localparam logic [8:0] LINE_FLD_END_EVN = 9'd272;

    // Configuration reset values
    localparam logic [8:0] FIRST_VIDEO_RST = 9'd40;
    localparam logic [8:0] LAST_VIDEO_RST  = 9'd264;
    localparam logic [3:0] LINE_REPEAT_RST = 4'd2;

    typedef enum logic [6:0] {
        PH_VSYNC      = 7'b0000001,
        PH_PAD        = 7'b0000010,
        PH_SOUND      = 7'b0000100,
        PH_FRAME      = 7'b0001000,
        PH_WAIT_VIDEO = 7'b0010000,
        PH_VIDEO      = 7'b0100000,
        PH_FIELD_END  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [8:0] video_start;
        logic [8:0] last_video_line;
        logic [3:0] line_repeat;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [8:0]  scan_count;
        logic        even_flag;
        logic        vsync_flag;
        logic        video_flag;
        logic        period_half;
        logic [1:0]  pulse_select;
        logic [3:0]  repeat_count;
        logic [7:0]  row_count;
        logic [15:0] frame_timer;
        logic [15:0] sound_count;
        logic [31:0] ticks;
    } t_state;

    typedef struct packed {
        logic        half_line_period;
        logic [1:0]  pulse_kind;
        logic        video_on;
        logic [7:0]  row_index;
        logic        even_field;
        logic        in_vsync;
        logic        read_pad_strobe;
        logic        sound_stop_strobe;
        logic        frame_timer_busy;
        logic        sound_timer_busy;
        logic [8:0]  line_count;
        logic [31:0] tick_count;
    } t_result;

endpackage

// ===== rtl/nss_step.sv =====
// Next-state and result logic for one sequencer item.
`timescale 1ns / 1ps

module nss_step (
    input  nss_pkg::t_state  i_state,
    input  nss_pkg::t_cfg    i_cfg,
    input  logic [1:0]       i_command,
    input  logic [15:0]      i_load_value,
    output nss_pkg::t_state  o_state,
    output nss_pkg::t_result o_result
);
    import nss_pkg::*;

    logic       pad;
    logic       stop;
    logic [3:0] rpt;
    logic [3:0] rep_inc;

    always_comb begin
        o_state = i_state;
        pad     = 1'b0;
        stop    = 1'b0;
        rpt     = (i_cfg.line_repeat == 4'd0) ? 4'd1 : i_cfg.line_repeat;
        rep_inc = i_state.repeat_count + 4'd1;

        case (i_command)
            CMD_LOAD_FRAME: begin
                o_state.frame_timer = i_load_value;
            end
            CMD_LOAD_SOUND: begin
                o_state.sound_count = i_load_value;
            end
            CMD_TICK: begin
                o_state.scan_count = i_state.scan_count + 9'd1;
                o_state.ticks      = i_state.ticks + 32'd1;
                case (i_state.phase)
                    PH_VSYNC: begin
                        if (o_state.scan_count == LINE_HALF_START) begin
                            o_state.period_half  = 1'b1;
                            o_state.pulse_select = PULSE_SERR;
                        end else if (o_state.scan_count == LINE_BROAD) begin
                            o_state.pulse_select = PULSE_BROAD;
                        end else if (o_state.scan_count == LINE_SERR_AGAIN) begin
                            o_state.pulse_select = PULSE_SERR;
                        end else if ((o_state.scan_count == LINE_VS_END_ODD
                                      && !i_state.even_flag)
                                     || o_state.scan_count == LINE_VS_END_EVN) begin
                            o_state.period_half  = 1'b0;
                            o_state.pulse_select = PULSE_HSYNC;
                            o_state.vsync_flag   = 1'b0;
                            o_state.phase        = PH_PAD;
                        end
                    end
                    PH_PAD: begin
                        pad           = 1'b1;
                        o_state.phase = PH_SOUND;
                    end
                    PH_SOUND: begin
                        if (i_state.sound_count != 16'd0) begin
                            o_state.sound_count = i_state.sound_count - 16'd1;
                            stop = (i_state.sound_count == 16'd1);
                        end
                        o_state.phase = PH_FRAME;
                    end
                    PH_FRAME: begin
                        if (i_state.frame_timer != 16'd0) begin
                            o_state.frame_timer = i_state.frame_timer - 16'd1;
                        end
                        o_state.phase = PH_WAIT_VIDEO;
                    end
                    PH_WAIT_VIDEO: begin
                        if (o_state.scan_count == i_cfg.video_start) begin
                            o_state.video_flag   = 1'b1;
                            o_state.repeat_count = 4'd0;
                            o_state.row_count    = 8'd0;
                            o_state.phase        = PH_VIDEO;
                        end
                    end
                    PH_VIDEO: begin
                        if (rep_inc >= rpt) begin
                            o_state.repeat_count = 4'd0;
                            o_state.row_count    = i_state.row_count + 8'd1;
                        end else begin
                            o_state.repeat_count = rep_inc;
                        end
                        if (o_state.scan_count == i_cfg.last_video_line) begin
                            o_state.video_flag = 1'b0;
                            o_state.phase      = PH_FIELD_END;
                        end
                    end
                    PH_FIELD_END: begin
                        if ((o_state.scan_count == LINE_FLD_END_ODD && !i_state.even_flag)
                            || o_state.scan_count == LINE_FLD_END_EVN) begin
                            // even field closes on a half line
                            if (!(o_state.scan_count == LINE_FLD_END_ODD
                                  && !i_state.even_flag)) begin
                                o_state.period_half = 1'b1;
                            end
                            o_state.even_flag  = ~i_state.even_flag;
                            o_state.vsync_flag = 1'b1;
                            o_state.phase      = PH_VSYNC;
                            o_state.scan_count = 9'd0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        o_result.half_line_period  = o_state.period_half;
        o_result.pulse_kind        = o_state.pulse_select;
        o_result.video_on          = o_state.video_flag;
        o_result.row_index         = o_state.row_count;
        o_result.even_field        = o_state.even_flag;
        o_result.in_vsync          = o_state.vsync_flag;
        o_result.read_pad_strobe   = pad;
        o_result.sound_stop_strobe = stop;
        o_result.frame_timer_busy  = (o_state.frame_timer != 16'd0);
        o_result.sound_timer_busy  = (o_state.sound_count != 16'd0);
        o_result.line_count        = o_state.scan_count;
        o_result.tick_count        = o_state.ticks;
    end

endmodule

// ===== rtl/ntsc_scanline_sequencer.sv =====
// Top level of the NTSC interlaced scan line sequencer.
`timescale 1ns / 1ps

// Latency: a result is valid the cycle after its input transfer (one register stage).
// Throughput: one item per cycle unless a held result stalls o_in_ready; the state update
//   and result logic sit in a single pass between the state and result registers.
// o_in_ready stays high while the result register is empty or being drained.
// Reset (synchronous, i_rst_n low): vertical sync phase, even field, all counters and
//   timers zero, config to first line 40, last line 264, line repeat 2; no result held.
module ntsc_scanline_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_load_value,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_half_line_period,
    output logic [1:0]  o_pulse_kind,
    output logic        o_video_on,
    output logic [7:0]  o_row_index,
    output logic        o_even_field,
    output logic        o_in_vsync,
    output logic        o_read_pad_strobe,
    output logic        o_sound_stop_strobe,
    output logic        o_frame_timer_busy,
    output logic        o_sound_timer_busy,
    output logic [8:0]  o_line_count,
    output logic [31:0] o_tick_count
);
    import nss_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    in_xfer;

    // Result register frees up in the same cycle it is drained.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;

    nss_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_command    (i_command),
        .i_load_value (i_load_value),
        .o_state      (n_state),
        .o_result     (n_res)
    );

    // Config registers; writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.video_start      <= FIRST_VIDEO_RST;
            r_cfg.last_video_line  <= LAST_VIDEO_RST;
            r_cfg.line_repeat      <= LINE_REPEAT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FIRST_VIDEO: r_cfg.video_start      <= i_cfg_data;
                CFG_LAST_VIDEO:  r_cfg.last_video_line  <= i_cfg_data;
                CFG_LINE_REPEAT: r_cfg.line_repeat      <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer state advances on each item transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_VSYNC;
            r_state.scan_count   <= 9'd0;
            r_state.even_flag    <= 1'b1;
            r_state.vsync_flag   <= 1'b0;
            r_state.video_flag   <= 1'b0;
            r_state.period_half  <= 1'b0;
            r_state.pulse_select <= PULSE_HSYNC;
            r_state.repeat_count <= 4'd0;
            r_state.row_count    <= 8'd0;
            r_state.frame_timer  <= 16'd0;
            r_state.sound_count  <= 16'd0;
            r_state.ticks        <= 32'd0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // Result register: valid flag under reset, payload loads on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_half_line_period  = r_res.half_line_period;
    assign o_pulse_kind        = r_res.pulse_kind;
    assign o_video_on          = r_res.video_on;
    assign o_row_index         = r_res.row_index;
    assign o_even_field        = r_res.even_field;
    assign o_in_vsync          = r_res.in_vsync;
    assign o_read_pad_strobe   = r_res.read_pad_strobe;
    assign o_sound_stop_strobe = r_res.sound_stop_strobe;
    assign o_frame_timer_busy  = r_res.frame_timer_busy;
    assign o_sound_timer_busy  = r_res.sound_timer_busy;
    assign o_line_count        = r_res.line_count;
    assign o_tick_count        = r_res.tick_count;

    // Every line tick moves the tick counter by exactly one.
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_command == CMD_TICK) |=> r_state.ticks == $past(r_state.ticks) + 32'd1)
        else $error("tick counter did not advance by one");

    // A frame timer load lands in the timer unchanged.
    a_frame_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_command == CMD_LOAD_FRAME)
        |=> r_state.frame_timer == $past(i_load_value))
        else $error("frame timer load lost");

    // Stop strobe only when the sound timer has just reached zero.
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.sound_stop_strobe) |-> !r_res.sound_timer_busy)
        else $error("sound stop strobe with timer still busy");

    // Pad strobe and vsync never overlap the video window.
    a_no_video_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.read_pad_strobe || r_res.in_vsync)) |-> !r_res.video_on)
        else $error("video window open during vsync or pad strobe");

    // Non-tick commands never move the scan line.
    a_load_holds_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_command != CMD_TICK) |=> $stable(r_state.scan_count))
        else $error("scan line moved on a non-tick command");

endmodule

// ===== tb/sv/tb_ntsc_scanline_sequencer.sv =====
// Self-checking testbench for the NTSC scan line sequencer, with a line-by-line predictor.
`timescale 1ns / 1ps

module tb_ntsc_scanline_sequencer;

    import nss_pkg::*;

    // Command code 3 has no meaning; the block must report its state unchanged.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Receiver hold-off long enough to back the item channel up.
    localparam int HOLD_CYCLES     = 400;
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 4000;
    // Quiet cycles after the last result.
    localparam int TAIL_CYCLES     = 8;

    // Result of a reset block: even field, everything else zero.
    localparam t_result AFTER_RESET = '{
        half_line_period:  1'b0,
        pulse_kind:        PULSE_HSYNC,
        video_on:          1'b0,
        row_index:         8'd0,
        even_field:        1'b1,
        in_vsync:          1'b0,
        read_pad_strobe:   1'b0,
        sound_stop_strobe: 1'b0,
        frame_timer_busy:  1'b0,
        sound_timer_busy:  1'b0,
        line_count:        9'd0,
        tick_count:        32'd0
    };

    // One row of the directed table; "typed" rows carry a hand-written result.
    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] val;
        bit          typed;
        t_result     want;
    } t_line_row;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_command = CMD_TICK;
    logic [15:0] i_load_value = 16'd0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_FIRST_VIDEO;
    logic [8:0]  i_cfg_data = 9'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_half_line_period;
    logic [1:0]  o_pulse_kind;
    logic        o_video_on;
    logic [7:0]  o_row_index;
    logic        o_even_field;
    logic        o_in_vsync;
    logic        o_read_pad_strobe;
    logic        o_sound_stop_strobe;
    logic        o_frame_timer_busy;
    logic        o_sound_timer_busy;
    logic [8:0]  o_line_count;
    logic [31:0] o_tick_count;

    ntsc_scanline_sequencer DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_command           (i_command),
        .i_load_value        (i_load_value),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_half_line_period  (o_half_line_period),
        .o_pulse_kind        (o_pulse_kind),
        .o_video_on          (o_video_on),
        .o_row_index         (o_row_index),
        .o_even_field        (o_even_field),
        .o_in_vsync          (o_in_vsync),
        .o_read_pad_strobe   (o_read_pad_strobe),
        .o_sound_stop_strobe (o_sound_stop_strobe),
        .o_frame_timer_busy  (o_frame_timer_busy),
        .o_sound_timer_busy  (o_sound_timer_busy),
        .o_line_count        (o_line_count),
        .o_tick_count        (o_tick_count)
    );

    // 2 ns clock period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer model: shadow copy of the config and the line state
    // ------------------------------------------------------------------
    logic [8:0]  cfg_first  = FIRST_VIDEO_RST;
    logic [8:0]  cfg_last   = LAST_VIDEO_RST;
    logic [3:0]  cfg_repeat = LINE_REPEAT_RST;

    t_phase      seq_phase  = PH_VSYNC;
    logic [8:0]  line_no    = 9'd0;
    logic        even_q     = 1'b1;
    logic        vs_q       = 1'b0;
    logic        video_q    = 1'b0;
    logic        half_q     = 1'b0;
    logic [1:0]  pulse_q    = PULSE_HSYNC;
    logic [3:0]  rep_q      = 4'd0;
    logic [7:0]  row_q      = 8'd0;
    logic [15:0] frame_q    = 16'd0;
    logic [15:0] sound_q    = 16'd0;
    logic [31:0] tick_q     = 32'd0;

    // Results owed by the block, oldest first
    t_result     line_results_due[$];

    // Bookkeeping
    int          error_count    = 0;
    int          items_sent     = 0;
    int          ticks_sent     = 0;
    int          results_seen   = 0;
    int          cfg_writes     = 0;
    int          settings_run   = 0;
    int          fields_done    = 0;
    int          idle_cycles    = 0;
    bit          rx_steady      = 1'b0;
    bit          hold_req       = 1'b0;

    // Vertical sync over: back to full lines and hsync, gamepad phase next.
    function automatic void leave_vsync();
        half_q    = 1'b0;
        pulse_q   = PULSE_HSYNC;
        vs_q      = 1'b0;
        seq_phase = PH_PAD;
    endfunction

    // Field over: swap field parity, restart the line count in vertical sync.
    function automatic void flip_field();
        even_q    = ~even_q;
        vs_q      = 1'b1;
        seq_phase = PH_VSYNC;
        line_no   = 9'd0;
        fields_done++;
    endfunction

    // Advance the model by one item and return the result line it owes.
    function automatic t_result predict_line(input logic [1:0] cmd, input logic [15:0] val);
        t_result    r;
        logic [3:0] rpt;
        logic       pad;
        logic       stop;
        pad  = 1'b0;
        stop = 1'b0;
        // a repeat of zero acts as one
        rpt  = (cfg_repeat == 4'd0) ? 4'd1 : cfg_repeat;
        case (cmd)
            CMD_LOAD_FRAME: frame_q = val;
            CMD_LOAD_SOUND: sound_q = val;
            CMD_TICK: begin
                line_no = line_no + 9'd1;
                tick_q  = tick_q + 32'd1;
                case (seq_phase)
                    PH_VSYNC: begin
                        if (line_no == LINE_HALF_START) begin
                            half_q  = 1'b1;
                            pulse_q = PULSE_SERR;
                        end else if (line_no == LINE_BROAD) begin
                            pulse_q = PULSE_BROAD;
                        end else if (line_no == LINE_SERR_AGAIN) begin
                            pulse_q = PULSE_SERR;
                        end else if (line_no == LINE_VS_END_ODD) begin
                            if (!even_q) leave_vsync();
                        end else if (line_no == LINE_VS_END_EVN) begin
                            leave_vsync();
                        end
                    end
                    PH_PAD: begin
                        pad       = 1'b1;
                        seq_phase = PH_SOUND;
                    end
                    PH_SOUND: begin
                        if (sound_q != 16'd0) begin
                            sound_q = sound_q - 16'd1;
                            if (sound_q == 16'd0) stop = 1'b1;
                        end
                        seq_phase = PH_FRAME;
                    end
                    PH_FRAME: begin
                        if (frame_q != 16'd0) frame_q = frame_q - 16'd1;
                        seq_phase = PH_WAIT_VIDEO;
                    end
                    PH_WAIT_VIDEO: begin
                        if (line_no == cfg_first) begin
                            video_q   = 1'b1;
                            rep_q     = 4'd0;
                            row_q     = 8'd0;
                            seq_phase = PH_VIDEO;
                        end
                    end
                    PH_VIDEO: begin
                        // restart as soon as the count reaches or passes the repeat
                        rep_q = rep_q + 4'd1;
                        if (rep_q >= rpt) begin
                            rep_q = 4'd0;
                            row_q = row_q + 8'd1;
                        end
                        if (line_no == cfg_last) begin
                            video_q   = 1'b0;
                            seq_phase = PH_FIELD_END;
                        end
                    end
                    PH_FIELD_END: begin
                        if (line_no == LINE_FLD_END_ODD && !even_q) begin
                            flip_field();
                        end else if (line_no == LINE_FLD_END_EVN) begin
                            half_q = 1'b1;
                            flip_field();
                        end
                    end
                    default: ;
                endcase
            end
            default: ;   // unused command: state untouched
        endcase
        r.half_line_period  = half_q;
        r.pulse_kind        = pulse_q;
        r.video_on          = video_q;
        r.row_index         = row_q;
        r.even_field        = even_q;
        r.in_vsync          = vs_q;
        r.read_pad_strobe   = pad;
        r.sound_stop_strobe = stop;
        r.frame_timer_busy  = (frame_q != 16'd0);
        r.sound_timer_busy  = (sound_q != 16'd0);
        r.line_count        = line_no;
        r.tick_count        = tick_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle gap: mostly none or short, now and then long.
    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)      return 0;
        else if (sel < 85) return $urandom_range(1, 3);
        else if (sel < 97) return $urandom_range(4, 10);
        else               return $urandom_range(20, 60);
    endfunction

    function automatic t_line_row mk_row(input logic [1:0] cmd, input logic [15:0] val,
                                         input bit typed, input t_result want);
        t_line_row row;
        row.cmd   = cmd;
        row.val   = val;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // Offer one item, hold it until the transfer, then log what it must produce.
    // Valid is lowered only when a gap follows, so it never dips between
    // back-to-back items.
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] val, input int gap,
                             input bit typed, input t_result typed_res);
        t_result pred;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_load_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        pred = predict_line(cmd, val);
        line_results_due.push_back(typed ? typed_res : pred);
        items_sent++;
        if (cmd == CMD_TICK) ticks_sent++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait for every owed result to come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (line_results_due.size() != 0) @(posedge i_clk);
    endtask

    // One register write; the model picks it up at the transfer.
    task automatic cfg_write(input logic [1:0] idx, input logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FIRST_VIDEO: cfg_first  = data;
            CFG_LAST_VIDEO:  cfg_last   = data;
            CFG_LINE_REPEAT: cfg_repeat = data[3:0];
            default: ;
        endcase
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain, load a window/repeat setting, then stream random items until
    // n_ticks line ticks have gone in. Mostly ticks, since only a run of
    // ticks walks the field; loads and the unused code are sprinkled in.
    // hold_at / pause_at pick the tick at which the receiver holds off or
    // the sender waits for a full drain (-1 for none).
    task automatic run_phase(input logic [8:0] first, input logic [8:0] last,
                             input logic [8:0] rpt_data, input int n_ticks, input bit steady,
                             input int hold_at, input int pause_at);
        int          done;
        int          sel;
        logic [1:0]  cmd;
        logic [15:0] val;
        done = 0;
        wait_drained();
        cfg_write(CFG_FIRST_VIDEO, first);
        cfg_write(CFG_LAST_VIDEO, last);
        cfg_write(CFG_LINE_REPEAT, rpt_data);
        settings_run++;
        rx_steady = steady;
        while (done < n_ticks) begin
            sel = $urandom_range(0, 99);
            if (sel < 92)      cmd = CMD_TICK;
            else if (sel < 96) cmd = CMD_LOAD_FRAME;
            else if (sel < 99) cmd = CMD_LOAD_SOUND;
            else               cmd = CMD_UNUSED;
            // small counts let the sound timer run out within a field
            sel = $urandom_range(0, 9);
            if (sel < 4)       val = 16'($urandom_range(0, 3));
            else if (sel == 4) val = 16'd0;
            else if (sel == 5) val = 16'hFFFF;
            else               val = 16'($urandom);
            if (cmd == CMD_TICK) done++;
            if (cmd == CMD_TICK && done == hold_at) hold_req = 1'b1;
            send_item(cmd, val, steady ? 0 : gap_len(), 1'b0, AFTER_RESET);
            if (cmd == CMD_TICK && done == pause_at) wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_line(input t_result want);
        check_field("half_line_period",  32'(want.half_line_period),
                    32'(o_half_line_period));
        check_field("pulse_kind",        32'(want.pulse_kind),        32'(o_pulse_kind));
        check_field("video_on",          32'(want.video_on),          32'(o_video_on));
        check_field("row_index",         32'(want.row_index),         32'(o_row_index));
        check_field("even_field",        32'(want.even_field),        32'(o_even_field));
        check_field("in_vsync",          32'(want.in_vsync),          32'(o_in_vsync));
        check_field("read_pad_strobe",   32'(want.read_pad_strobe),
                    32'(o_read_pad_strobe));
        check_field("sound_stop_strobe", 32'(want.sound_stop_strobe),
                    32'(o_sound_stop_strobe));
        check_field("frame_timer_busy",  32'(want.frame_timer_busy),
                    32'(o_frame_timer_busy));
        check_field("sound_timer_busy",  32'(want.sound_timer_busy),
                    32'(o_sound_timer_busy));
        check_field("line_count",        32'(want.line_count),        32'(o_line_count));
        check_field("tick_count",        want.tick_count,             o_tick_count);
    endtask

    // Outputs are sampled at the edge, before the block's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (line_results_due.size() == 0) begin
                $display("%0t ns: result transfer with nothing outstanding, line %0d tick %0d",
                         $time, o_line_count, o_tick_count);
                error_count++;
            end else begin
                check_line(line_results_due.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, optional long hold-off counted here
    // ------------------------------------------------------------------
    initial begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends a run that stops moving
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, line_results_due.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_line_row  dir_rows[$];
        t_result    lit;
        logic [8:0] f;
        logic [8:0] l;
        logic [4:0] hi;
        logic [3:0] lo;
        int         k;

        // Directed table, run on the reset settings (40 / 264 / repeat 2).
        // Unused code and loads from reset, timers at both extremes.
        dir_rows.push_back(mk_row(CMD_UNUSED, 16'hFFFF, 1'b1, AFTER_RESET));
        lit = AFTER_RESET;
        lit.frame_timer_busy = 1'b1;
        dir_rows.push_back(mk_row(CMD_LOAD_FRAME, 16'hFFFF, 1'b1, lit));
        lit.sound_timer_busy = 1'b1;
        dir_rows.push_back(mk_row(CMD_LOAD_SOUND, 16'hFFFF, 1'b1, lit));
        lit.frame_timer_busy = 1'b0;
        dir_rows.push_back(mk_row(CMD_LOAD_FRAME, 16'h0000, 1'b1, lit));
        dir_rows.push_back(mk_row(CMD_LOAD_SOUND, 16'h0000, 1'b1, AFTER_RESET));
        // first tick: half-line periods and serration start; load value ignored
        lit = AFTER_RESET;
        lit.half_line_period = 1'b1;
        lit.pulse_kind       = PULSE_SERR;
        lit.line_count       = 9'd1;
        lit.tick_count       = 32'd1;
        dir_rows.push_back(mk_row(CMD_TICK, 16'hFFFF, 1'b1, lit));
        // sound timer at one runs out on the sound phase of this field
        dir_rows.push_back(mk_row(CMD_LOAD_SOUND, 16'd1, 1'b0, AFTER_RESET));
        dir_rows.push_back(mk_row(CMD_LOAD_FRAME, 16'd2, 1'b0, AFTER_RESET));
        // walk through the broad pulses and back to serration (line 13)
        for (k = 0; k < 12; k++)
            dir_rows.push_back(mk_row(CMD_TICK, k[0] ? 16'hFFFF : 16'h0000, 1'b0,
                                      AFTER_RESET));
        dir_rows.push_back(mk_row(CMD_UNUSED, 16'h0000, 1'b0, AFTER_RESET));
        dir_rows.push_back(mk_row(CMD_LOAD_FRAME, 16'h8000, 1'b0, AFTER_RESET));

        // reset asserted once, then released
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].cmd, dir_rows[i].val, gap_len(), dir_rows[i].typed,
                      dir_rows[i].want);

        // Rest of the even field up to its end at line 272, window to 271 and
        // repeat 0 (upper data bits set); no idling, and the receiver holds
        // off long enough to stall input.
        run_phase(9'd23, 9'd271, 9'h1F0, 259, 1'b1, 100, -1);
        // Odd field: sync ends at line 18, window opens with the largest
        // repeat; the sender drains once midway.
        run_phase(9'd40, 9'd200, 9'd15, 100, 1'b0, -1, 50);
        // Repeat cut to 3 mid-window, so the count may already be past it
        run_phase(9'd40, 9'd200, 9'd3, 60, 1'b0, -1, -1);
        // Window closes at 230, odd field ends at line 271
        run_phase(9'd40, 9'd230, 9'd2, 115, 1'b0, -1, -1);
        // Random windows and repeats
        for (k = 0; k < 2; k++) begin
            f  = 9'($urandom_range(19, 60));
            l  = 9'($urandom_range(200, 272));
            hi = 5'($urandom_range(0, 31));
            lo = 4'($urandom_range(0, 15));
            run_phase(f, l, {hi, lo}, $urandom_range(20, 40), 1'b0, -1, -1);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items (%0d line ticks), %0d register settings, %0d writes",
                 items_sent, ticks_sent, settings_run, cfg_writes);
        $display("%0d result lines compared across %0d field changes, %0d mismatches",
                 results_seen, fields_done, error_count);
        if (error_count == 0 && line_results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
